### hw/rtl/stkd_pkg.sv
// ----------------------------------------------------------------------------
// stkd_pkg
// Shared types and codes for the stack with indexed delete.
// ----------------------------------------------------------------------------
package stkd_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W  = 4;

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_LIST   = 2'd2,
      CMD_DELETE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_INVALID   = 2'd3
   } status_type;

   // what every cell does in a cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_POP,
      CELL_ROTATE,
      CELL_DELETE
   } cell_op_type;

   typedef enum logic {
      S_IDLE,
      S_LIST
   } state_type;

endpackage

### hw/rtl/stkd_req_if.sv
// ----------------------------------------------------------------------------
// stkd_req_if
// Command channel: valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
interface stkd_req_if;

   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [31:0] push_value;
   logic [3:0]         position;

   modport source (output valid, output command, output push_value, output position,
                   input ready);
   modport sink   (input valid, input command, input push_value, input position,
                   output ready);

endinterface

### hw/rtl/stkd_rsp_if.sv
// ----------------------------------------------------------------------------
// stkd_rsp_if
// Result channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface stkd_rsp_if;

   logic               valid;
   logic               ready;
   logic signed [31:0] read_value;
   logic [1:0]         status;
   logic               last;

   modport source (output valid, output read_value, output status, output last,
                   input ready);
   modport sink   (input valid, input read_value, input status, input last,
                   output ready);

endinterface

### hw/rtl/stack_with_delete_at_position_core.sv
// ----------------------------------------------------------------------------
// stack_with_delete_at_position_core
// Bounded LIFO of signed 32-bit words with push, pop, list and indexed delete.
// ----------------------------------------------------------------------------
// The stack lives in a row of DEPTH cells with the top in cell 0. Push, pop
// and delete each complete when accepted: every cell loads from its neighbor
// or holds, and one result item is registered. List is accepted without a
// result and then gives one result per stored entry, stalling while the
// output register is full, the row rotating once per result so the top is
// always in cell 0; the command channel is held off until the last entry has
// gone out. A new command is taken while the previous result still waits in
// the output register, provided that register drains in the same cycle.
module stack_with_delete_at_position_core
   import stkd_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   stkd_req_if.sink   req_ch,
   stkd_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rem_ff, rem_in;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   status_type               rsp_status_ff;
   logic                     rsp_last_ff;

   logic                     load_rsp;
   logic signed [DATA_W-1:0] load_value;
   status_type               load_status;
   logic                     load_last;

   cell_op_type      cell_op;
   logic [CNT_W-1:0] mark;
   logic             slot_free;
   logic             req_ready;
   logic             accept;
   logic             empty;
   logic             full;
   logic             pos_bad;
   cmd_type          cmd;

   logic signed [DATA_W-1:0] cell_data [DEPTH];

   // --- cell row ---
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [DATA_W-1:0] prev_d;
      logic signed [DATA_W-1:0] next_d;

      if (g == 0) begin : g_first
         assign prev_d = cell_data[0];
      end else begin : g_mid
         assign prev_d = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_end
         assign next_d = cell_data[g];
      end else begin : g_inner
         assign next_d = cell_data[g+1];
      end

      stkd_cell #(
         .INDEX (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .mark       (mark),
         .push_value (req_ch.push_value),
         .head_data  (cell_data[0]),
         .prev_data  (prev_d),
         .next_data  (next_d),
         .data       (cell_data[g])
      );
   end

   // --- control ---
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign cmd       = cmd_type'(req_ch.command);
   assign pos_bad   = (req_ch.position == '0) ||
                      (CMP_W'(req_ch.position) > CMP_W'(count_ff));
   assign accept    = req_ch.valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rem_in      = rem_ff;
      req_ready   = 1'b0;
      load_rsp    = 1'b0;
      load_value  = '0;
      load_status = ST_OK;
      load_last   = 1'b1;
      cell_op     = CELL_HOLD;
      mark        = '0;

      case (state_ff)
         S_IDLE: begin
            req_ready = slot_free;
            if (req_ch.valid && slot_free) begin
               load_rsp = 1'b1;
               case (cmd)
                  CMD_PUSH: begin
                     if (full) begin
                        load_status = ST_OVERFLOW;
                     end else begin
                        cell_op  = CELL_PUSH;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_POP: begin
                     if (empty) begin
                        load_status = ST_UNDERFLOW;
                     end else begin
                        load_value = cell_data[0];
                        cell_op    = CELL_POP;
                        count_in   = count_ff - 1'b1;
                     end
                  end
                  CMD_LIST: begin
                     if (empty) begin
                        load_status = ST_UNDERFLOW;
                     end else begin
                        load_rsp = 1'b0;
                        rem_in   = count_ff;
                        state_in = S_LIST;
                     end
                  end
                  default: begin
                     if (empty) begin
                        load_status = ST_UNDERFLOW;
                     end else if (pos_bad) begin
                        load_status = ST_INVALID;
                     end else begin
                        // bottom-based position p sits in cell count - p
                        cell_op  = CELL_DELETE;
                        mark     = count_ff - CNT_W'(req_ch.position);
                        count_in = count_ff - 1'b1;
                     end
                  end
               endcase
            end
         end
         S_LIST: begin
            if (slot_free) begin
               load_rsp   = 1'b1;
               load_value = cell_data[0];
               load_last  = (rem_ff == CNT_W'(1));
               cell_op    = CELL_ROTATE;
               mark       = count_ff - 1'b1;
               rem_in     = rem_ff - 1'b1;
               if (rem_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rem_ff   <= rem_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_value_ff  <= load_value;
         rsp_status_ff <= load_status;
         rsp_last_ff   <= load_last;
      end
   end

   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_value_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.last       = rsp_last_ff;

   // --- checks ---
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("stack count above depth");

   a_list_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LIST |-> !req_ready)
      else $error("command taken during list");

   a_list_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST && slot_free && rem_ff == CNT_W'(1)) |=>
         (state_ff == S_IDLE && rsp_last_ff))
      else $error("list did not end on last entry");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == CMD_PUSH && !full) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not grow the stack");

endmodule

### hw/rtl/stkd_cell.sv
// ----------------------------------------------------------------------------
// stkd_cell
// One stack slot. Cell 0 holds the top; cells hand entries to neighbors.
// ----------------------------------------------------------------------------
module stkd_cell
   import stkd_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 4
) (
   input  logic                     clock,
   input  cell_op_type              op,
   input  logic [CNT_W-1:0]         mark,
   input  logic signed [DATA_W-1:0] push_value,
   input  logic signed [DATA_W-1:0] head_data,
   input  logic signed [DATA_W-1:0] prev_data,
   input  logic signed [DATA_W-1:0] next_data,
   output logic signed [DATA_W-1:0] data
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic                     at_mark;
   logic                     above_mark;

   assign at_mark    = (CNT_W'(INDEX) == mark);
   assign above_mark = (CNT_W'(INDEX) >= mark);

   always_comb begin
      data_in = data_ff;
      case (op)
         CELL_PUSH:   data_in = (INDEX == 0) ? push_value : prev_data;
         CELL_POP:    data_in = next_data;
         // tail of the live region takes the head, the rest move up
         CELL_ROTATE: data_in = at_mark ? head_data : next_data;
         CELL_DELETE: data_in = above_mark ? next_data : data_ff;
         default:     data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
